// ===== design/icy_pkg.sv =====
// Package for the ICY metadata demultiplexer: byte kinds, stream constants
// and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icy_pkg;

  localparam int unsigned IntervalW = 24;
  localparam int unsigned MetaCntW  = 12;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned KindW     = 3;
  localparam int unsigned LenShift  = 4;

  localparam logic [ByteW-1:0]    QuoteChar   = 8'h27;
  localparam logic [MetaCntW-1:0] TitleStart  = 12'd13;
  localparam logic [MetaCntW-1:0] SearchStart = 12'd14;

  typedef enum logic [KindW-1:0] {
    KIND_AUDIO   = 3'd0,
    KIND_LENGTH  = 3'd1,
    KIND_META    = 3'd2,
    KIND_TITLE   = 3'd3,
    KIND_RESTART = 3'd4
  } kind_t;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ===== design/icy_metadata_demux.sv =====
// ICY metadata demultiplexer: tags each stream byte as audio, length byte,
// metadata or title byte, and each restart as a restart result. Depends on icy_pkg.
//
// An accepted input transaction's result is registered and shows in the cycle after.
// Throughput: one transaction per cycle; the result register drains while
// the next byte is taken, so only a stalled output with a full result
// register holds off the input.
// Reset: synchronous; counters, flags, meta_interval and out_valid clear.
`timescale 1ns / 1ps
`default_nettype none

module icy_metadata_demux
  import icy_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [IntervalW-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 operation,
  input  wire logic [ByteW-1:0]     data_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [KindW-1:0]          byte_kind,
  output logic [ByteW-1:0]          out_byte,
  output logic                      meta_last,
  output logic                      title_valid
);

  logic [IntervalW-1:0] meta_interval;
  logic [IntervalW-1:0] audio_left, audio_left_next;
  logic [MetaCntW-1:0]  meta_left, meta_left_next;
  logic [MetaCntW-1:0]  meta_index, meta_index_next;
  logic                 title_open, title_open_next;
  logic                 quote_found, quote_found_next;

  kind_t            kind_next;
  kind_t            kind_q;
  logic [ByteW-1:0] byte_next;
  logic             last_next;
  logic             valid_next;
  logic             in_fire;
  logic [MetaCntW-1:0] len_bytes;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign len_bytes = {data_byte, {LenShift{1'b0}}};

  always_comb begin
    audio_left_next  = audio_left;
    meta_left_next   = meta_left;
    meta_index_next  = meta_index;
    title_open_next  = title_open;
    quote_found_next = quote_found;
    kind_next        = KIND_AUDIO;
    byte_next        = data_byte;
    last_next        = 1'b0;
    valid_next       = 1'b0;
    priority if (op_t'(operation) == OP_RESTART) begin
      audio_left_next  = meta_interval;
      meta_left_next   = '0;
      meta_index_next  = '0;
      title_open_next  = 1'b0;
      quote_found_next = 1'b0;
      kind_next        = KIND_RESTART;
      byte_next        = '0;
    end else if (meta_interval == '0) begin
      kind_next = KIND_AUDIO;
    end else if (meta_left != '0) begin
      kind_next = KIND_META;
      if (meta_index == TitleStart) begin
        kind_next = KIND_TITLE;
      end else if (meta_index >= SearchStart && title_open) begin
        if (data_byte == QuoteChar) begin
          title_open_next  = 1'b0;
          quote_found_next = 1'b1;
        end else begin
          kind_next = KIND_TITLE;
        end
      end
      meta_index_next = meta_index + 1'b1;
      meta_left_next  = meta_left - 1'b1;
      if (meta_left == MetaCntW'(1)) begin
        last_next        = 1'b1;
        valid_next       = quote_found_next;
        audio_left_next  = meta_interval;
        meta_index_next  = '0;
        title_open_next  = 1'b0;
        quote_found_next = 1'b0;
      end
    end else if (audio_left == '0) begin
      kind_next        = KIND_LENGTH;
      meta_left_next   = len_bytes;
      meta_index_next  = '0;
      quote_found_next = 1'b0;
      title_open_next  = (len_bytes != '0);
      if (len_bytes == '0) begin
        audio_left_next = meta_interval;
      end
    end else begin
      kind_next       = KIND_AUDIO;
      audio_left_next = audio_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_interval <= '0;
      audio_left    <= '0;
      meta_left     <= '0;
      meta_index    <= '0;
      title_open    <= 1'b0;
      quote_found   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        meta_interval <= cfg_data;
      end
      if (in_fire) begin
        audio_left  <= audio_left_next;
        meta_left   <= meta_left_next;
        meta_index  <= meta_index_next;
        title_open  <= title_open_next;
        quote_found <= quote_found_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_q      <= kind_next;
      out_byte    <= byte_next;
      meta_last   <= last_next;
      title_valid <= valid_next;
    end
  end

  assign byte_kind = kind_q;

  a_title_in_block: assert property (@(posedge clk) disable iff (rst)
    title_open |-> meta_left != '0)
    else $error("title open outside a metadata block");

  a_quote_closes_title: assert property (@(posedge clk) disable iff (rst)
    !(quote_found && title_open))
    else $error("title still open after closing quote");

  a_last_is_meta: assert property (@(posedge clk) disable iff (rst)
    out_valid && meta_last |-> kind_q == KIND_META || kind_q == KIND_TITLE)
    else $error("block end flagged on a non-metadata byte");

  a_valid_needs_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && title_valid |-> meta_last)
    else $error("title_valid without meta_last");

  a_restart_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && operation |=> out_valid && kind_q == KIND_RESTART && out_byte == '0)
    else $error("restart did not produce a restart result");

endmodule

`default_nettype wire

// ===== tb/sv/tb_icy_metadata_demux.sv =====
// Self-checking testbench for icy_metadata_demux: random ICY frames with
// titles, restarts and interval changes, checked against an in-bench model.
// Depends on icy_pkg and the icy_metadata_demux RTL.
`timescale 1ns / 1ps

module tb_icy_metadata_demux;
  import icy_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    op_t              op;
    logic [ByteW-1:0] data;
  } stream_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic             last;
    logic             tvalid;
  } tag_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [IntervalW-1:0] cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 operation   = OP_BYTE;
  logic [ByteW-1:0]     data_byte   = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [KindW-1:0]     byte_kind;
  logic [ByteW-1:0]     out_byte;
  logic                 meta_last;
  logic                 title_valid;

  icy_metadata_demux dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_kind   (byte_kind),
    .out_byte    (out_byte),
    .meta_last   (meta_last),
    .title_valid (title_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  stream_item_t stream_q[$];
  tag_t         tag_q[$];

  // Demux state mirrored by the predictor
  logic [IntervalW-1:0] interval_cfg = '0;
  logic [IntervalW-1:0] audio_cnt    = '0;
  logic [MetaCntW-1:0]  meta_cnt     = '0;
  logic [MetaCntW-1:0]  meta_pos     = '0;
  logic                 title_on     = 1'b0;
  logic                 quote_seen   = 1'b0;

  int unsigned n_queued   = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_title    = 0;
  int unsigned n_closed   = 0;
  int unsigned n_cfg      = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned tx_gap     = 0;
  int unsigned rx_stall   = 0;
  int unsigned hold_cnt   = 0;
  bit          tx_idle    = 1'b0;
  bit          rx_idle    = 1'b0;
  bit          hold_go    = 1'b0;
  bit          holding    = 1'b0;
  bit          hold_done  = 1'b0;
  tag_t        want;

  function automatic int unsigned idle_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
  endfunction

  function automatic tag_t tag_byte(input op_t op, input logic [ByteW-1:0] b);
    tag_t r;
    r = '{KIND_AUDIO, b, 1'b0, 1'b0};
    if (op == OP_RESTART) begin
      audio_cnt  = interval_cfg;
      meta_cnt   = '0;
      meta_pos   = '0;
      title_on   = 1'b0;
      quote_seen = 1'b0;
      r = '{KIND_RESTART, 8'h00, 1'b0, 1'b0};
    end else if (interval_cfg == 0) begin
      r.kind = KIND_AUDIO;
    end else if (meta_cnt != 0) begin
      r.kind = KIND_META;
      if (meta_pos == TitleStart) begin
        r.kind = KIND_TITLE;
      end else if (meta_pos >= SearchStart && title_on) begin
        if (b == QuoteChar) begin
          title_on   = 1'b0;
          quote_seen = 1'b1;
        end else begin
          r.kind = KIND_TITLE;
        end
      end
      meta_pos = meta_pos + 1'b1;
      meta_cnt = meta_cnt - 1'b1;
      if (meta_cnt == 0) begin
        r.last     = 1'b1;
        r.tvalid   = quote_seen;
        audio_cnt  = interval_cfg;
        meta_pos   = '0;
        title_on   = 1'b0;
        quote_seen = 1'b0;
      end
    end else if (audio_cnt == 0) begin
      meta_cnt   = {b, 4'h0};
      meta_pos   = '0;
      quote_seen = 1'b0;
      title_on   = (meta_cnt != 0);
      if (meta_cnt == 0) audio_cnt = interval_cfg;
      r.kind = KIND_LENGTH;
    end else begin
      audio_cnt = audio_cnt - 1'b1;
      r.kind    = KIND_AUDIO;
    end
    return r;
  endfunction

  // Driver: offer queued transactions, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) tag_q.push_back(tag_byte(op_t'(operation), data_byte));
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap = tx_gap - 1;
          in_valid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          in_valid  <= 1'b1;
          operation <= stream_q[0].op;
          data_byte <= stream_q[0].data;
          void'(stream_q.pop_front());
          if (tx_idle && $urandom_range(0, 3) == 0) tx_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off to fill the block and stall its input
  always @(posedge clk) begin
    if (rst) begin
      holding   <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (holding) begin
      if (hold_cnt == HoldCycles) begin
        holding   <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end else if (hold_go && !hold_done) begin
      holding  <= 1'b1;
      hold_cnt <= 0;
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (tag_q.size() == 0) begin
          n_errors++;
          if (n_errors <= ReportLimit)
            $display("result with nothing expected: kind %0d byte %02h last %0b title %0b",
                     byte_kind, out_byte, meta_last, title_valid);
        end else begin
          want = tag_q.pop_front();
          n_checked++;
          if (byte_kind !== want.kind || out_byte !== want.data ||
              meta_last !== want.last || title_valid !== want.tvalid) begin
            n_errors++;
            if (n_errors <= ReportLimit)
              $display("mismatch on result %0d: expected kind %0d byte %02h last %0b title %0b, %s",
                       n_checked, want.kind, want.data, want.last, want.tvalid,
                       $sformatf("got kind %0d byte %02h last %0b title %0b",
                                 byte_kind, out_byte, meta_last, title_valid));
          end
          if (want.kind == KIND_TITLE) n_title++;
          if (want.last && want.tvalid) n_closed++;
        end
      end
      if (rx_stall != 0) begin
        rx_stall = rx_stall - 1;
        out_ready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        rx_stall = idle_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !holding;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d results checked",
               cycle_cnt, n_checked, n_queued);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_item(input op_t op, input logic [ByteW-1:0] b);
    stream_q.push_back('{op, b});
    n_queued++;
  endtask

  // Length byte plus block content; a restart cuts the block short when keep is below its length
  task automatic push_meta(input logic [ByteW-1:0] len_byte, input int unsigned keep);
    int unsigned total;
    int unsigned close_at;
    logic [ByteW-1:0] b;
    total    = len_byte * 16;
    close_at = $urandom_range(SearchStart, total + 8);
    push_item(OP_BYTE, len_byte);
    for (int unsigned i = 0; i < total && i < keep; i++) begin
      b = $urandom;
      if (i == close_at || (i == TitleStart && $urandom_range(0, 3) == 0)) b = QuoteChar;
      else if (i > TitleStart && i < close_at && b == QuoteChar) b = 8'h20;
      push_item(OP_BYTE, b);
    end
    if (keep < total) push_item(OP_RESTART, $urandom);
  endtask

  task automatic gen_frames(input int unsigned ivl, input int unsigned budget);
    int unsigned stop_at;
    logic [ByteW-1:0] len_byte;
    stop_at = n_queued + budget;
    push_item(OP_RESTART, $urandom);
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 24) == 0) begin
        repeat ($urandom_range(1, 8)) push_item(OP_BYTE, $urandom);
        push_item(OP_RESTART, $urandom);
      end
      repeat (ivl) push_item(OP_BYTE, $urandom);
      case ($urandom_range(0, 19))
        0, 1: len_byte = 8'd0;
        2: len_byte = 8'hFF;
        3, 4, 5: len_byte = $urandom_range(2, 4);
        default: len_byte = 8'd1;
      endcase
      if (len_byte == 8'hFF || $urandom_range(0, 9) == 0)
        push_meta(len_byte, $urandom_range(0, 40));
      else
        push_meta(len_byte, len_byte * 16);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (n_checked != n_queued);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_interval(input logic [IntervalW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    interval_cfg = value;
    n_cfg++;
  endtask

  initial begin
    int unsigned ivl;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // Interval zero passes every byte as audio
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_RESTART, 8'hFF);
    wait_idle();
    write_interval(2);
    push_item(OP_RESTART, 8'h00);
    push_item(OP_BYTE, 8'hA5);
    push_item(OP_BYTE, 8'h5A);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h3C);
    push_item(OP_BYTE, 8'hC3);
    push_item(OP_BYTE, 8'h01);
    for (int i = 0; i < 13; i++) push_item(OP_BYTE, 8'h41 + i);
    push_item(OP_BYTE, QuoteChar);
    push_item(OP_BYTE, 8'h54);
    push_item(OP_BYTE, QuoteChar);
    wait_idle();

    // Tightest interval, no idling
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    write_interval(1);
    gen_frames(1, 350);
    wait_idle();

    // Back-to-back sender against a long receiver hold-off
    rx_idle = 1'b1;
    hold_go = 1'b1;
    ivl = $urandom_range(3, 12);
    write_interval(ivl);
    gen_frames(ivl, 450);
    repeat (ivl) push_item(OP_BYTE, $urandom);
    push_item(OP_BYTE, 8'h02);
    repeat (7) push_item(OP_BYTE, $urandom);
    wait_idle();

    // Interval zero with a block left open, then a nonzero interval from a zero count
    tx_idle = 1'b1;
    write_interval(0);
    repeat (60) push_item(OP_BYTE, $urandom);
    push_item(OP_RESTART, $urandom);
    wait_idle();
    write_interval(24'hFFFFFF);
    push_meta(8'h01, 16);
    repeat (30) push_item(OP_BYTE, $urandom);
    push_item(OP_RESTART, $urandom);
    repeat (20) push_item(OP_BYTE, $urandom);
    wait_idle();

    ivl = $urandom_range(13, 40);
    write_interval(ivl);
    gen_frames(ivl, 600);
    wait_idle();
    repeat (5) @(posedge clk);

    $display("Checked %0d transactions over %0d interval settings: %0d title bytes, %0d %s",
             n_checked, n_cfg, n_title, n_closed, "blocks closed with a found title");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
